### design/sha_pkg.sv
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic absorb;      // write the input byte into the buffer
    logic start;       // load working variables and begin rounds
    logic round;       // run one round
    logic fold;        // add working variables into the hash
    logic pad_first;   // build the first padding block
    logic pad_len;     // build a length-only padding block
    logic emit_next;   // advance the digest word pointer
    logic restart;     // load the initial hash and clear counters
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic block_full;  // the absorbed byte completes a block
    logic rounds_done; // the last round is running
    logic pad_two;     // padding needs two blocks
    logic last_emit;   // word seven is on the output
  } status_t;

  localparam int unsigned Rounds = 64;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/sha_ctrl.sv
module sha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sha_pkg::in_item_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sha_pkg::status_t sts_i,
  output sha_pkg::cmd_t    cmd_o
);

  sha_pkg::state_e state_q, state_d;
  // Set while a compression belongs to padding; flags whether another pad block follows it.
  logic fin_q, fin_d;
  logic more_q, more_d;
  logic take;

  assign take = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    more_d  = more_q;
    case (state_q)
      sha_pkg::ST_IDLE: begin
        if (take) begin
          fin_d = in_data_i.end_of_message;
          if (in_data_i.byte_present && sts_i.block_full) begin
            state_d = sha_pkg::ST_COMPRESS;
            fin_d   = 1'b0;
            more_d  = in_data_i.end_of_message;
          end else if (in_data_i.end_of_message) begin
            state_d = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        state_d = sha_pkg::ST_COMPRESS;
        fin_d   = 1'b1;
        more_d  = sts_i.pad_two;
      end
      sha_pkg::ST_COMPRESS: begin
        if (sts_i.rounds_done) begin
          if (fin_q && more_q) begin
            state_d = sha_pkg::ST_COMPRESS;
            more_d  = 1'b0;
          end else if (fin_q) begin
            state_d = sha_pkg::ST_EMIT;
          end else if (more_q) begin
            state_d = sha_pkg::ST_PAD;
          end else begin
            state_d = sha_pkg::ST_IDLE;
          end
        end
      end
      sha_pkg::ST_EMIT: begin
        if (out_ready_i && sts_i.last_emit) begin
          state_d = sha_pkg::ST_IDLE;
          fin_d   = 1'b0;
        end
      end
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      sha_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.absorb = take && in_data_i.byte_present;
        cmd_o.start  = take && in_data_i.byte_present && sts_i.block_full;
      end
      sha_pkg::ST_PAD: begin
        cmd_o.pad_first = 1'b1;
        cmd_o.start     = 1'b1;
      end
      sha_pkg::ST_COMPRESS: begin
        cmd_o.round = 1'b1;
        cmd_o.fold  = sts_i.rounds_done;
        // Second padding block: length only, started in the same cycle as the fold.
        cmd_o.pad_len = sts_i.rounds_done && fin_q && more_q;
        cmd_o.start   = cmd_o.pad_len;
      end
      sha_pkg::ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_next = out_ready_i;
        cmd_o.restart   = out_ready_i && sts_i.last_emit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      fin_q   <= 1'b0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      more_q  <= more_d;
    end
  end

endmodule

### design/sha_datapath.sv
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::in_item_t in_data_i,
  input  sha_pkg::cmd_t     cmd_i,
  output sha_pkg::status_t  sts_o,
  output sha_pkg::out_item_t out_data_o
);

  logic [5:0]  cnt_q;
  logic [63:0] bits_q;
  logic [31:0] hash_q [8];
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q;
  logic [2:0]  emit_q;

  logic [31:0] w_new, t1, t2, s0, s1, e, a;
  logic [31:0] blk_word [16];

  assign sts_o.block_full  = (cnt_q == 6'd63);
  assign sts_o.rounds_done = (rnd_q == 6'(sha_pkg::Rounds - 1));
  assign sts_o.pad_two     = (cnt_q > 6'd55);
  assign sts_o.last_emit   = (emit_q == 3'd7);

  assign out_data_o.digest_word = hash_q[emit_q];
  assign out_data_o.word_index  = emit_q;
  assign out_data_o.last_word   = (emit_q == 3'd7);

  // The schedule window doubles as the byte buffer; padding bytes replace
  // its contents at and after the fill point, or all of it for a length-only block.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        logic [7:0] b;
        b = w_q[i][31 - 8 * j -: 8];
        if (cmd_i.pad_len) begin
          b = 8'h00;
        end else if (cmd_i.pad_first) begin
          if (6'(4 * i + j) == cnt_q) begin
            b = 8'h80;
          end else if (6'(4 * i + j) > cnt_q) begin
            b = 8'h00;
          end
        end
        blk_word[i][31 - 8 * j -: 8] = b;
      end
    end
    // The bit length closes every padding block that has room for it.
    if (cmd_i.pad_len || (cmd_i.pad_first && cnt_q < 6'd56)) begin
      blk_word[14] = bits_q[63:32];
      blk_word[15] = bits_q[31:0];
    end
  end

  // Message schedule word and round function.
  always_comb begin
    s1    = sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
    s0    = sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
    w_new = (rnd_q < 6'd16) ? w_q[0] : s1 + w_q[9] + s0 + w_q[0];
    a     = v_q[0];
    e     = v_q[4];
    t1 = v_q[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
       + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::RoundK[rnd_q] + w_new;
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Schedule window: w_q[0] is the word of the current round while rnd_q is below 16,
  // and W[t-16] after that. Between blocks incoming bytes are written into it big-endian at the fill point.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= blk_word[i];
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
    end
    if (cmd_i.absorb) begin
      w_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= in_data_i.data_byte;
    end
  end

  // Hash state, byte and bit counters, round and emit pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha_pkg::InitHash[i];
      end
      cnt_q  <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      emit_q <= '0;
    end else begin
      if (cmd_i.absorb) begin
        cnt_q  <= cnt_q + 6'd1;
        bits_q <= bits_q + 64'd8;
      end
      if (cmd_i.round) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.fold) begin
        hash_q[0] <= hash_q[0] + t1 + t2;
        hash_q[1] <= hash_q[1] + v_q[0];
        hash_q[2] <= hash_q[2] + v_q[1];
        hash_q[3] <= hash_q[3] + v_q[2];
        hash_q[4] <= hash_q[4] + v_q[3] + t1;
        hash_q[5] <= hash_q[5] + v_q[4];
        hash_q[6] <= hash_q[6] + v_q[5];
        hash_q[7] <= hash_q[7] + v_q[6];
      end
      if (cmd_i.emit_next) begin
        emit_q <= emit_q + 3'd1;
      end
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= sha_pkg::InitHash[i];
        end
        cnt_q  <= '0;
        bits_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      // The second pad block starts on the fold cycle, so it takes the new hash.
      if (cmd_i.fold) begin
        v_q[0] <= hash_q[0] + t1 + t2;
        v_q[1] <= hash_q[1] + v_q[0];
        v_q[2] <= hash_q[2] + v_q[1];
        v_q[3] <= hash_q[3] + v_q[2];
        v_q[4] <= hash_q[4] + v_q[3] + t1;
        v_q[5] <= hash_q[5] + v_q[4];
        v_q[6] <= hash_q[6] + v_q[5];
        v_q[7] <= hash_q[7] + v_q[6];
      end else begin
        for (int i = 0; i < 8; i++) begin
          v_q[i] <= hash_q[i];
        end
      end
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= e;
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= a;
      v_q[0] <= t1 + t2;
    end
  end

endmodule

### design/sha256_stream_hasher.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid_i/ready_o  | in_data_i  (sha_pkg::in_item_t)
// out     | output    | out_valid_o/ready_i | out_data_o (sha_pkg::out_item_t)
//
// A byte that does not complete a block is absorbed into the buffer. A full block
// then runs through the single round unit, one round per cycle.
// End of message adds a first padded block, sometimes a second, and then eight
// digest transfers. Reset loads the initial hash;
// out_ready_i low holds a word.
module sha256_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_data_o
);

  sha_pkg::cmd_t    cmd;
  sha_pkg::status_t sts;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .in_data_i, .cmd_i(cmd), .sts_o(sts), .out_data_o
  );

endmodule

### design/sha_checker.sv
module sha_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sha_pkg::out_item_t out_data_o
);

  // Input and output never transfer together.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("in and out both open");

  // The last flag marks word seven exactly.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd7)))
    else $error("last flag mismatch");

  // Word indexes step by one after each transfer but that of the last word.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_word) |=>
      (out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("word index skipped");

  // After the last word the block accepts input again.
  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_word) |=> in_ready_o)
    else $error("not idle after digest");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

### tb/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  sha_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  sha_pkg::out_item_t out_data_o;

  sha256_stream_hasher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Predicted hasher state.
  logic [31:0] run_hash [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] msg_bit_len;

  sha_pkg::out_item_t digest_q [$];
  int                 mismatch_count;
  bit                 idle_off;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rot_r(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of the buffered block into the running hash.
  task automatic compress_blk();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, s0, s1, a, e;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 0; i < 8; i++) v[i] = run_hash[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s1 = rot_r(w[(t-2)&15], 17) ^ rot_r(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        s0 = rot_r(w[(t-15)&15], 7) ^ rot_r(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        wt = s1 + w[(t-7)&15] + s0 + w[t&15];
        w[t&15] = wt;
      end
      a = v[0];
      e = v[4];
      t1 = v[7] + (rot_r(e, 6) ^ rot_r(e, 11) ^ rot_r(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
           + sha_pkg::RoundK[t] + wt;
      t2 = (rot_r(a, 2) ^ rot_r(a, 13) ^ rot_r(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = e;
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = a;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) run_hash[i] = run_hash[i] + v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) run_hash[i] = sha_pkg::InitHash[i];
    blk_fill = 0;
    msg_bit_len = '0;
  endtask

  // Absorb one accepted item and queue the digest words it produces.
  task automatic predict_digest(input sha_pkg::in_item_t it);
    int unsigned        pos;
    sha_pkg::out_item_t o;
    if (it.byte_present) begin
      blk_bytes[blk_fill] = it.data_byte;
      blk_fill++;
      msg_bit_len += 64'd8;
      if (blk_fill == 64) begin
        compress_blk();
        blk_fill = 0;
      end
    end
    if (!it.end_of_message) return;
    pos = blk_fill;
    blk_bytes[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) blk_bytes[i] = 8'h00;
      compress_blk();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) blk_bytes[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bit_len[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = run_hash[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      digest_q.push_back(o);
    end
    restart_hash();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Sender: one transfer, with random idle gaps beforehand.
  task automatic send_item(input logic [7:0] b, input logic pres, input logic eom);
    sha_pkg::in_item_t it;
    while (!idle_off && $urandom_range(99) < 33) @(negedge clk_i);
    it.data_byte = b;
    it.byte_present = pres;
    it.end_of_message = eom;
    in_data_i = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_digest(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len - 1; i++) send_item(8'($urandom), 1'b1, 1'b0);
    if (len > 0) send_item(8'($urandom), 1'b1, 1'b1);
    else send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (digest_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls on the ready line.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= idle_off || ($urandom_range(99) >= 33);
  end

  // Result checker.
  always @(posedge clk_i) begin
    sha_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_data_o.digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (out_data_o.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data_o.digest_word, want.digest_word);
        if (out_data_o.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_data_o.word_index), 32'(want.word_index));
        if (out_data_o.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_data_o.last_word), 32'(want.last_word));
      end
    end
  end

  // Empty messages, byte extremes, ignored data and idle items.
  task automatic test_directed();
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b1);
    wait_drained();
  endtask

  // The shortest message that needs two padding blocks.
  task automatic test_pad_boundaries();
    send_message(56);
    wait_drained();
  endtask

  // Short random messages with stray idle items mixed in.
  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 10) begin
      len = $urandom_range(6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b0);
      end
      send_item(8'($urandom), 1'($urandom), 1'b1);
      sent += len + 1;
    end
  endtask

  // A full block of back-to-back transfers with no idling on either side.
  task automatic test_full_throughput();
    idle_off = 1'b1;
    send_message(64);
    wait_drained();
    idle_off = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    idle_off = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    restart_hash();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_pad_boundaries();
    test_full_throughput();
    test_random_messages();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && digest_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
